FILE: rtl/core/smms_pkg.sv
package smms_pkg;

    // window geometry
    localparam int unsigned WINDOW_SIZE_DEF = 240;
    localparam int unsigned COORD_W         = 8;
    localparam int unsigned PIX_W           = 8;

    // weight arithmetic
    localparam int unsigned WEIGHT_W = 27;
    localparam int unsigned REWARD_W = 10;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX  = 27'sd67108863;
    localparam logic signed [WEIGHT_W-1:0] PEN_THRESH  = 27'sd100;
    localparam logic signed [WEIGHT_W-1:0] PEN_STEP    = 27'sd1000;
    localparam logic signed [WEIGHT_W-1:0] FREE_THRESH = 27'sd1;
    localparam logic signed [WEIGHT_W-1:0] FREE_STEP   = 27'sd10;
    localparam logic [REWARD_W-1:0]        FREE_REWARD = 10'd10;

    // pixel codes
    localparam logic [PIX_W-1:0] PIX_OBSTACLE = 8'd0;
    localparam logic [PIX_W-1:0] PIX_UNKNOWN  = 8'd205;
    localparam logic [PIX_W-1:0] PIX_FREE     = 8'd255;

    // register file
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_FREE_SPACE_MODE = 1'b0;  // word index, paddr[2]

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_OBS_PENALTY,
        OP_FREE_PENALTY
    } t_op;

    typedef struct packed {
        logic                first;
        logic                last;
        t_op                 op;
        logic [REWARD_W-1:0] amount;
    } t_score_cmd;

    // graded obstacle reward by global shade
    function automatic logic [REWARD_W-1:0] obstacle_reward(input logic [PIX_W-1:0] m);
        logic [REWARD_W-1:0] r;
        case (m)
            8'd0:    r = 10'd1000;
            8'd20:   r = 10'd900;
            8'd40:   r = 10'd800;
            8'd60:   r = 10'd700;
            8'd80:   r = 10'd600;
            8'd100:  r = 10'd500;
            8'd120:  r = 10'd400;
            8'd140:  r = 10'd300;
            8'd160:  r = 10'd200;
            8'd180:  r = 10'd100;
            8'd200:  r = 10'd50;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/smms_if.sv
interface smms_item_if;
    logic                        valid;
    logic                        ready;
    logic                        first_cell;
    logic                        last_cell;
    logic [smms_pkg::COORD_W-1:0] cell_col;
    logic [smms_pkg::COORD_W-1:0] cell_row;
    logic [smms_pkg::PIX_W-1:0]   scan_value;
    logic [smms_pkg::PIX_W-1:0]   map_value;

    modport source (
        output valid, first_cell, last_cell, cell_col, cell_row, scan_value, map_value,
        input  ready
    );
    modport sink (
        input  valid, first_cell, last_cell, cell_col, cell_row, scan_value, map_value,
        output ready
    );
endinterface

interface smms_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [smms_pkg::WEIGHT_W-1:0] match_weight;

    modport source (output valid, match_weight, input ready);
    modport sink   (input valid, match_weight, output ready);
endinterface

FILE: rtl/core/smms_cfg.sv
module smms_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [smms_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [smms_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic [smms_pkg::APB_DATA_W-1:0]   o_prdata,
    output logic                              o_pready,
    output logic                              o_free_mode
);

    logic r_free_mode;
    logic n_free_mode;
    logic w_wr;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_comb begin
        n_free_mode = r_free_mode;
        if (w_wr && i_paddr[2] == smms_pkg::REG_FREE_SPACE_MODE) begin
            n_free_mode = i_pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_mode <= 1'b0;
        end else begin
            r_free_mode <= n_free_mode;
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr[2] == smms_pkg::REG_FREE_SPACE_MODE) begin
            o_prdata[0] = r_free_mode;
        end
    end

    assign o_free_mode = r_free_mode;

endmodule

FILE: rtl/core/smms_decode.sv
module smms_decode #(
    parameter int unsigned WINDOW_SIZE = smms_pkg::WINDOW_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_free_mode,
    smms_item_if.sink             i_item,
    output smms_pkg::t_score_cmd  o_cmd,
    output logic                  o_cmd_vld
);

    localparam int unsigned HALF   = WINDOW_SIZE / 2;
    localparam int unsigned HALF_W = $clog2(HALF + 1);
    localparam int unsigned D_W    =
        ((HALF_W > smms_pkg::COORD_W) ? HALF_W : smms_pkg::COORD_W) + 1;
    localparam int unsigned SQ_W   = 2 * D_W;
    localparam logic [SQ_W:0] R_SQ = (SQ_W + 1)'(HALF * HALF);

    // input register
    logic                          r_in_vld;
    logic                          r_first;
    logic                          r_last;
    logic [smms_pkg::COORD_W-1:0]  r_col;
    logic [smms_pkg::COORD_W-1:0]  r_row;
    logic [smms_pkg::PIX_W-1:0]    r_scan;
    logic [smms_pkg::PIX_W-1:0]    r_map;

    // command register
    logic                          r_cmd_vld;
    smms_pkg::t_score_cmd          r_cmd;
    smms_pkg::t_score_cmd          n_cmd;

    logic signed [D_W-1:0]         w_dx;
    logic signed [D_W-1:0]         w_dy;
    logic signed [SQ_W-1:0]        w_dx_ext;
    logic signed [SQ_W-1:0]        w_dy_ext;
    logic [SQ_W-1:0]               w_dx2;
    logic [SQ_W-1:0]               w_dy2;
    logic [SQ_W:0]                 w_dist2;
    logic                          w_in_circle;

    assign i_item.ready = i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_cmd_vld <= 1'b0;
        end else if (i_adv) begin
            r_in_vld  <= i_item.valid;
            r_cmd_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_first <= i_item.first_cell;
            r_last  <= i_item.last_cell;
            r_col   <= i_item.cell_col;
            r_row   <= i_item.cell_row;
            r_scan  <= i_item.scan_value;
            r_map   <= i_item.map_value;
            r_cmd   <= n_cmd;
        end
    end

    // inscribed circle test
    assign w_dx     = $signed(D_W'(r_col)) - $signed(D_W'(HALF));
    assign w_dy     = $signed(D_W'(HALF)) - $signed(D_W'(r_row));
    assign w_dx_ext = SQ_W'(w_dx);
    assign w_dy_ext = SQ_W'(w_dy);
    assign w_dx2    = $unsigned(w_dx_ext * w_dx_ext);
    assign w_dy2    = $unsigned(w_dy_ext * w_dy_ext);
    assign w_dist2  = {1'b0, w_dx2} + {1'b0, w_dy2};
    assign w_in_circle = (w_dist2 < R_SQ);

    always_comb begin
        n_cmd.first  = r_first;
        n_cmd.last   = r_last;
        n_cmd.op     = smms_pkg::OP_NONE;
        n_cmd.amount = '0;
        if (w_in_circle) begin
            if (r_scan == smms_pkg::PIX_OBSTACLE) begin
                if (r_map == smms_pkg::PIX_UNKNOWN || r_map == smms_pkg::PIX_FREE) begin
                    n_cmd.op = smms_pkg::OP_OBS_PENALTY;
                end else begin
                    n_cmd.op     = smms_pkg::OP_ADD;
                    n_cmd.amount = smms_pkg::obstacle_reward(r_map);
                end
            end else if (r_scan == smms_pkg::PIX_FREE && i_free_mode) begin
                if (r_map == smms_pkg::PIX_FREE) begin
                    n_cmd.op     = smms_pkg::OP_ADD;
                    n_cmd.amount = smms_pkg::FREE_REWARD;
                end else if (r_map == smms_pkg::PIX_UNKNOWN) begin
                    n_cmd.op = smms_pkg::OP_FREE_PENALTY;
                end
            end
        end
    end

    assign o_cmd     = r_cmd;
    assign o_cmd_vld = r_cmd_vld;

endmodule

FILE: rtl/core/smms_accum.sv
module smms_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smms_pkg::t_score_cmd  i_cmd,
    input  logic                  i_cmd_vld,
    smms_result_if.source         o_result,
    output logic                  o_adv
);

    localparam int unsigned W = smms_pkg::WEIGHT_W;

    logic signed [W-1:0] r_weight;
    logic signed [W-1:0] n_weight;
    logic                r_out_vld;
    logic signed [W-1:0] r_out_w;

    logic signed [W-1:0] w_base;
    logic signed [W:0]   w_sum;

    // whole pipeline moves whenever the result slot is free or being drained
    assign o_adv = !r_out_vld || o_result.ready;

    assign w_base = i_cmd.first ? '0 : r_weight;
    assign w_sum  = $signed({w_base[W-1], w_base}) + $signed((W + 1)'(i_cmd.amount));

    always_comb begin
        case (i_cmd.op)
            smms_pkg::OP_ADD: begin
                if (w_sum > $signed({1'b0, smms_pkg::WEIGHT_MAX})) begin
                    n_weight = smms_pkg::WEIGHT_MAX;
                end else begin
                    n_weight = w_sum[W-1:0];
                end
            end
            smms_pkg::OP_OBS_PENALTY: begin
                n_weight = (w_base > smms_pkg::PEN_THRESH) ? w_base - smms_pkg::PEN_STEP : '0;
            end
            smms_pkg::OP_FREE_PENALTY: begin
                n_weight = (w_base > smms_pkg::FREE_THRESH) ? w_base - smms_pkg::FREE_STEP
                                                            : w_base;
            end
            default: begin
                n_weight = w_base;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight  <= '0;
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            if (i_cmd_vld) begin
                r_weight <= n_weight;
            end
            r_out_vld <= i_cmd_vld && i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_cmd_vld && i_cmd.last) begin
            r_out_w <= n_weight;
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.match_weight = r_out_w;

endmodule

FILE: rtl/core/scan_map_match_scorer.sv
// Channel   Dir  Handshake       Payload
// i_item    in   valid / ready   first_cell, last_cell, cell_col, cell_row,
//                                scan_value, map_value
// o_result  out  valid / ready   match_weight (27b signed), one word per last_cell
// APB       in   psel/penable    reg 0 @ 0x0: free_space_mode (bit 0)
//
// One cell word per cycle while the result side keeps up; a result word passes
// input reg -> decode reg -> result reg after its last_cell word is taken.
// The running weight update (add or subtract, saturate, select) is combinational.
// Synchronous active-low reset clears the weight, free_space_mode and all valids.
// A stalled result freezes the whole pipe; i_item.ready drops only while the
// result register is full and not being taken.
module scan_map_match_scorer #(
    parameter int unsigned WINDOW_SIZE = smms_pkg::WINDOW_SIZE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    smms_item_if.sink                        i_item,
    smms_result_if.source                    o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [smms_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [smms_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [smms_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    logic                 w_free_mode;
    logic                 w_adv;
    smms_pkg::t_score_cmd w_cmd;
    logic                 w_cmd_vld;

    // config registers
    smms_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata),
        .o_pready    (pready),
        .o_free_mode (w_free_mode)
    );

    // input register, circle test and cell classification
    smms_decode #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_free_mode (w_free_mode),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_vld   (w_cmd_vld)
    );

    // running weight and result register
    smms_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_cmd_vld (w_cmd_vld),
        .o_result  (o_result),
        .o_adv     (w_adv)
    );

endmodule

FILE: rtl/core/smms_checker.sv
module smms_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [smms_pkg::WEIGHT_W-1:0] i_match_weight
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_match_weight))
        else $error("result word changed while stalled");

    // guarded subtraction keeps the weight at or above its floor
    a_weight_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_match_weight >= -27'sd899)
        else $error("match_weight below floor");

    // empty result slot never blocks input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result slot");

    // reset drops the result valid
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind scan_map_match_scorer smms_checker u_smms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_match_weight (o_result.match_weight)
);

FILE: tb/sv/smms_weight_checker.sv
module smms_weight_checker #(
    parameter int unsigned WINDOW_SIZE = smms_pkg::WINDOW_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    smms_item_if                            cells,
    smms_result_if                          weights,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [smms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [smms_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            pready,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int MAX_REPORTS = 10;

    logic                                 free_mode;
    logic signed [smms_pkg::WEIGHT_W-1:0] window_weight;
    logic signed [smms_pkg::WEIGHT_W-1:0] pending_weights[$];
    int                                   fail_count;
    int                                   result_count;

    // reward for a scan obstacle over a graded global shade
    function automatic int shade_reward(input logic [smms_pkg::PIX_W-1:0] m);
        if (m <= 8'd180 && (m % 20) == 0) begin
            return 1000 - int'(m / 20) * 100;
        end
        if (m == 8'd200) begin
            return 50;
        end
        return 0;
    endfunction

    function automatic int clip_high(input int s);
        return (s > smms_pkg::WEIGHT_MAX) ? int'(smms_pkg::WEIGHT_MAX) : s;
    endfunction

    function automatic logic signed [smms_pkg::WEIGHT_W-1:0] score_cell(
        input logic signed [smms_pkg::WEIGHT_W-1:0] w_in,
        input logic                                 fs_mode,
        input logic [smms_pkg::COORD_W-1:0]         col,
        input logic [smms_pkg::COORD_W-1:0]         row,
        input logic [smms_pkg::PIX_W-1:0]           scan,
        input logic [smms_pkg::PIX_W-1:0]           map
    );
        int w;
        int half;
        int dx;
        int dy;
        w    = w_in;
        half = WINDOW_SIZE / 2;
        dx   = int'(col) - half;
        dy   = half - int'(row);
        if (dx * dx + dy * dy < half * half) begin
            if (scan == smms_pkg::PIX_OBSTACLE) begin
                if (map == smms_pkg::PIX_UNKNOWN || map == smms_pkg::PIX_FREE) begin
                    w = (w > smms_pkg::PEN_THRESH) ? w - int'(smms_pkg::PEN_STEP) : 0;
                end else begin
                    w = clip_high(w + shade_reward(map));
                end
            end else if (scan == smms_pkg::PIX_FREE && fs_mode) begin
                if (map == smms_pkg::PIX_FREE) begin
                    w = clip_high(w + int'(smms_pkg::FREE_STEP));
                end else if (map == smms_pkg::PIX_UNKNOWN && w > smms_pkg::FREE_THRESH) begin
                    w = w - int'(smms_pkg::FREE_STEP);
                end
            end
        end
        return w[smms_pkg::WEIGHT_W-1:0];
    endfunction

    function automatic void note_failure(input string what,
                                         input logic signed [smms_pkg::WEIGHT_W-1:0] exp_w,
                                         input logic signed [smms_pkg::WEIGHT_W-1:0] got_w);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("weight %0d %s: expected %0d, got %0d", result_count, what, exp_w, got_w);
        end
    endfunction

    initial begin
        free_mode     = 1'b0;
        window_weight = '0;
        fail_count    = 0;
        result_count  = 0;
        o_fail_count  = 0;
        o_pending     = 0;
    end

    always @(posedge i_clk) begin
        logic signed [smms_pkg::WEIGHT_W-1:0] w;
        logic signed [smms_pkg::WEIGHT_W-1:0] exp_w;
        if (!i_rst_n) begin
            free_mode     = 1'b0;
            window_weight = '0;
            pending_weights.delete();
        end else begin
            // register write lands on the access edge
            if (psel && penable && pwrite && pready
                    && paddr[2] == smms_pkg::REG_FREE_SPACE_MODE) begin
                free_mode = pwdata[0];
            end
            if (cells.valid && cells.ready) begin
                w = cells.first_cell ? '0 : window_weight;
                window_weight = score_cell(w, free_mode, cells.cell_col, cells.cell_row,
                                           cells.scan_value, cells.map_value);
                // newest at the front, oldest taken from the back
                if (cells.last_cell) begin
                    pending_weights.push_front(window_weight);
                end
            end
            if (weights.valid && weights.ready) begin
                if (pending_weights.size() == 0) begin
                    note_failure("unexpected", '0, weights.match_weight);
                end else begin
                    exp_w = pending_weights.pop_back();
                    if (weights.match_weight !== exp_w) begin
                        note_failure("mismatch", exp_w, weights.match_weight);
                    end
                end
                result_count++;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_weights.size();
    end

endmodule

FILE: tb/sv/tb_scan_map_match_scorer.sv
module tb_scan_map_match_scorer;

    // Timing knobs
    localparam int STALL_LIMIT  = 2000;   // cycles without any handshake
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;      // pipe is 3 deep, margin on top
    localparam int TAIL_CYCLES  = 20;
    localparam int LONG_CELLS   = 100;    // one long window of top rewards
    localparam int PHASE_CELLS  = 320;

    localparam logic [smms_pkg::APB_ADDR_W-1:0] FREE_MODE_ADDR =
        {smms_pkg::REG_FREE_SPACE_MODE, 2'b00};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [smms_pkg::APB_ADDR_W-1:0] paddr;
    logic [smms_pkg::APB_DATA_W-1:0] pwdata;
    logic [smms_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    int fail_count;
    int pending_count;
    int quiet_cycles = 0;

    // shared between stimulus and the result-side process
    bit idle_on  = 1'b0;
    bit hold_req = 1'b0;

    smms_item_if   cell_bus ();
    smms_result_if weight_bus ();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    scan_map_match_scorer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (cell_bus),
        .o_result (weight_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    smms_weight_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cells        (cell_bus),
        .weights      (weight_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Watchdog: any word moving on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cell_bus.valid && cell_bus.ready)
                || (weight_bus.valid && weight_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: one decision per falling edge. A requested hold-off wins,
    // then any running burst, then a fresh random burst when idling is on.
    initial begin
        int hold_left;
        int gap_left;
        hold_left        = 0;
        gap_left         = 0;
        weight_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                weight_bus.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                weight_bus.ready <= 1'b0;
            end else if (gap_left > 0) begin
                weight_bus.ready <= 1'b0;
                gap_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 14) - 1;
                weight_bus.ready <= 1'b0;
            end else begin
                weight_bus.ready <= 1'b1;
            end
        end
    end

    // Offer one cell word, maybe after an idle burst, and wait for it to go.
    task automatic send_cell(input logic first, input logic last,
                             input logic [smms_pkg::COORD_W-1:0] col,
                             input logic [smms_pkg::COORD_W-1:0] row,
                             input logic [smms_pkg::PIX_W-1:0] scan,
                             input logic [smms_pkg::PIX_W-1:0] map);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge i_clk);
            cell_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cell_bus.valid      <= 1'b1;
        cell_bus.first_cell <= first;
        cell_bus.last_cell  <= last;
        cell_bus.cell_col   <= col;
        cell_bus.cell_row   <= row;
        cell_bus.scan_value <= scan;
        cell_bus.map_value  <= map;
        do @(posedge i_clk); while (!cell_bus.ready);
    endtask

    task automatic stop_cells();
        @(negedge i_clk);
        cell_bus.valid <= 1'b0;
    endtask

    // Only called with the cell channel quiet.
    task automatic reg_write(input logic [smms_pkg::APB_ADDR_W-1:0] addr,
                             input logic [smms_pkg::APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // All weights back, then let cells without a last mark leave the pipe.
    task automatic settle();
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly the inner square, where the circle edge cuts through;
    // now and then anything the 8-bit field holds.
    function automatic logic [smms_pkg::COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 7) == 0) begin
            return smms_pkg::COORD_W'($urandom_range(0, 255));
        end
        return smms_pkg::COORD_W'($urandom_range(20, 219));
    endfunction

    function automatic logic [smms_pkg::PIX_W-1:0] pick_scan();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return smms_pkg::PIX_OBSTACLE;
            4, 5:       return smms_pkg::PIX_FREE;
            6:          return smms_pkg::PIX_UNKNOWN;
            default:    return smms_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Graded shades 0..200 in steps of 20 dominate; odd shades cover the rest.
    function automatic logic [smms_pkg::PIX_W-1:0] pick_map();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return smms_pkg::PIX_W'(20 * $urandom_range(0, 10));
            4:          return smms_pkg::PIX_UNKNOWN;
            5:          return smms_pkg::PIX_FREE;
            default:    return smms_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One random phase: mostly whole windows (first ... last) with random
    // content, the rest loose words with random marks.
    task automatic run_phase(input logic mode, input bit idle, input bit squeeze);
        int sent;
        int len;
        settle();
        if (squeeze) begin
            hold_req = 1'b1;
        end
        reg_write(FREE_MODE_ADDR, smms_pkg::APB_DATA_W'(mode));
        idle_on = idle;
        sent    = 0;
        while (sent < PHASE_CELLS) begin
            if ($urandom_range(0, 99) < 85) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    send_cell(k == 0, k == len - 1, pick_coord(), pick_coord(),
                              pick_scan(), pick_map());
                end
                sent += len;
            end else begin
                send_cell(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_coord(),
                          pick_coord(), pick_scan(), pick_map());
                sent++;
            end
        end
        stop_cells();
    endtask

    initial begin
        cell_bus.valid      = 1'b0;
        cell_bus.first_cell = 1'b0;
        cell_bus.last_cell  = 1'b0;
        cell_bus.cell_col   = '0;
        cell_bus.cell_row   = '0;
        cell_bus.scan_value = '0;
        cell_bus.map_value  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: free-space scoring on, no idling.
        reg_write(FREE_MODE_ADDR, smms_pkg::APB_DATA_W'(1));
        send_cell(1, 0, 120, 120, smms_pkg::PIX_OBSTACLE, 8'd0);     // top reward
        send_cell(0, 0, 120, 121, smms_pkg::PIX_OBSTACLE, 8'd200);   // lightest graded shade
        send_cell(0, 0, 121, 120, smms_pkg::PIX_OBSTACLE, 8'd20);
        send_cell(0, 0, 119, 119, smms_pkg::PIX_OBSTACLE, 8'd10);    // off-grid shade
        send_cell(0, 0, 100, 100, smms_pkg::PIX_OBSTACLE, smms_pkg::PIX_UNKNOWN); // penalty
        send_cell(0, 0, 140, 140, smms_pkg::PIX_FREE, smms_pkg::PIX_FREE);     // free/free
        send_cell(0, 0, 130, 110, smms_pkg::PIX_UNKNOWN, 8'd0);      // unknown scan
        send_cell(0, 1, 110, 130, smms_pkg::PIX_FREE, smms_pkg::PIX_UNKNOWN);  // emit
        send_cell(1, 1, 120, 120, smms_pkg::PIX_OBSTACLE, smms_pkg::PIX_FREE); // first+last
        send_cell(1, 0, 60, 120, smms_pkg::PIX_OBSTACLE, 8'd180);    // weight 100
        send_cell(0, 0, 120, 60, smms_pkg::PIX_OBSTACLE, smms_pkg::PIX_FREE);  // cleared
        send_cell(0, 0, 120, 120, smms_pkg::PIX_OBSTACLE, 8'd180);
        send_cell(0, 0, 120, 120, smms_pkg::PIX_OBSTACLE, 8'd200);   // 150
        send_cell(0, 0, 120, 120, smms_pkg::PIX_OBSTACLE, smms_pkg::PIX_UNKNOWN); // negative
        send_cell(0, 0, 120, 120, smms_pkg::PIX_FREE, smms_pkg::PIX_UNKNOWN);  // guard holds
        send_cell(0, 0, 120, 120, smms_pkg::PIX_FREE, smms_pkg::PIX_FREE);
        send_cell(0, 0, 0, 0, smms_pkg::PIX_OBSTACLE, 8'd0);         // corner, outside
        send_cell(0, 0, 255, 255, smms_pkg::PIX_OBSTACLE, 8'd0);     // beyond the window
        send_cell(0, 0, 240, 120, smms_pkg::PIX_OBSTACLE, 8'd0);     // exactly on the radius
        send_cell(0, 0, 120, 0, smms_pkg::PIX_OBSTACLE, 8'd0);
        send_cell(0, 0, 239, 120, smms_pkg::PIX_OBSTACLE, 8'd160);   // just inside
        send_cell(0, 0, 120, 239, smms_pkg::PIX_OBSTACLE, 8'd140);
        send_cell(0, 1, 1, 1, smms_pkg::PIX_OBSTACLE, 8'd0);         // diagonal corner, emit
        stop_cells();

        // Free-space scoring off: free scan cells leave the weight alone.
        settle();
        reg_write(FREE_MODE_ADDR, smms_pkg::APB_DATA_W'(0));
        send_cell(1, 0, 120, 120, smms_pkg::PIX_FREE, smms_pkg::PIX_FREE);
        send_cell(0, 1, 120, 120, smms_pkg::PIX_FREE, smms_pkg::PIX_UNKNOWN);
        stop_cells();

        // One long window of top rewards builds a large weight, then
        // single-cell windows carry on from it.
        settle();
        reg_write(FREE_MODE_ADDR, smms_pkg::APB_DATA_W'(1));
        idle_on = 1'b1;
        for (int k = 0; k < LONG_CELLS; k++) begin
            send_cell(k == 0, k == LONG_CELLS - 1,
                      smms_pkg::COORD_W'($urandom_range(40, 200)),
                      smms_pkg::COORD_W'($urandom_range(40, 200)),
                      smms_pkg::PIX_OBSTACLE, 8'd0);
        end
        send_cell(0, 1, 120, 120, smms_pkg::PIX_FREE, smms_pkg::PIX_FREE);
        send_cell(0, 1, 120, 120, smms_pkg::PIX_OBSTACLE, smms_pkg::PIX_UNKNOWN);
        send_cell(0, 1, 120, 120, smms_pkg::PIX_OBSTACLE, 8'd0);
        stop_cells();

        // Random phases; the second holds the result side off long enough to
        // back the pipe up into the cell channel. The last one runs flat out.
        run_phase(1'b0, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, 1'b1);
        run_phase(1'b0, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, 1'b0);
        run_phase(1'b1, 1'b0, 1'b0);

        while (pending_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: scan_map_match_scorer.f
rtl/core/smms_pkg.sv
rtl/core/smms_if.sv
rtl/core/smms_cfg.sv
rtl/core/smms_decode.sv
rtl/core/smms_accum.sv
rtl/core/scan_map_match_scorer.sv
rtl/core/smms_checker.sv
tb/sv/smms_weight_checker.sv
tb/sv/tb_scan_map_match_scorer.sv
